[src/gaussian_blur_3x3_rgb_defines.svh]
// ============================================================================
// gaussian_blur_3x3_rgb_defines
// Assertion macros shared by the blur RTL. They expand to concurrent
// assertions in simulation and to nothing when SYNTH is defined.
// ============================================================================
`ifndef GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define GBLUR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gaussian_blur_3x3_rgb: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define GBLUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gaussian_blur_3x3_rgb: next-cycle check failed");
`else
`define GBLUR_ASSERT_SAME(lbl, ante, cons)
`define GBLUR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/gblur_pkg.sv]
// ============================================================================
// gblur_pkg
// Types, constants and the per-channel kernel function of the 3x3 blur.
// ============================================================================
package gblur_pkg;

    // Row store depth and the address width that follows from it.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Fixed field widths.
    localparam int PIX_W     = 24;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 16;
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_W     = 56;

    // Register reset values.
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1
    } t_cfg_idx;

    // One 8-bit channel through the 1-2-1 / 2-4-2 / 1-2-1 kernel, truncated.
    function automatic logic [7:0] blur_chan(
        input logic [7:0] t0, input logic [7:0] t1, input logic [7:0] t2,
        input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] m2,
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2
    );
        logic [11:0] s;
        s = 12'(t0) + (12'(t1) << 1) + 12'(t2)
          + (12'(m0) << 1) + (12'(m1) << 2) + (12'(m2) << 1)
          + 12'(b0) + (12'(b1) << 1) + 12'(b2);
        return s[11:4];
    endfunction

endpackage

[src/gaussian_blur_3x3_rgb.sv]
// ============================================================================
// gaussian_blur_3x3_rgb
// Streaming 3x3 Gaussian blur of 24-bit RGB pixels with replicated borders.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------------
//  s (in)    slave      i_s_tvalid / o_s_tready   tdata: pixel_rgb
//  m (out)   master     o_m_tvalid / i_m_tready   tdata: rgb, column, row; tlast
//  cfg       slave      i_cfg_valid / o_cfg_ready index, data (width, height)
//
//  An item goes through a memory read stage, a window stage and an output
//  register.
//  One item per cycle is sustained while each item causes at most one result;
//  the last column and the last row emit up to four results per item, one per
//  cycle from the window stage, and the input stalls meanwhile.
//  Reset is synchronous and active low; the row stores are not cleared.
//  A full output register with i_m_tready low holds the pipeline.
//
`include "gaussian_blur_3x3_rgb_defines.svh"

module gaussian_blur_3x3_rgb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream: [23:0] pixel_rgb.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [23:0]                         i_s_tdata,
    // Output stream: [23:0] blurred_rgb, [34:24] out_column, [50:35] out_row,
    // [55:51] zero.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gblur_pkg::OUT_W-1:0]         o_m_tdata,
    output logic                                o_m_tlast,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gblur_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gblur_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int AW = gblur_pkg::ADDR_W;
    localparam int PW = gblur_pkg::PIX_W;
    localparam int WW = gblur_pkg::FW_W;
    localparam int HW = gblur_pkg::FH_W;

    // Configuration and position counters.
    logic [WW-1:0] r_fw;
    logic [HW-1:0] r_fh;
    logic [AW-1:0] r_col;
    logic [HW-1:0] r_row;

    // Read stage.
    logic          r_a_vld;
    logic [PW-1:0] r_a_pix;
    logic [AW-1:0] r_a_x;
    logic [HW-1:0] r_a_y;
    logic          r_a_lc;
    logic          r_a_lr;
    logic [PW-1:0] r_a_above;
    logic [PW-1:0] r_a_two;
    logic          r_a_fwd;
    logic [PW-1:0] r_a_fa;
    logic [PW-1:0] r_a_ft;

    // Window stage.
    logic [PW-1:0] r_win [3][3];
    logic [AW-1:0] r_b_x;
    logic [HW-1:0] r_b_y;
    logic [3:0]    r_b_pend;

    // Output register.
    logic                        r_o_vld;
    logic [gblur_pkg::OUT_W-1:0] r_o_data;
    logic                        r_o_last;

    // Row stores.
    logic [PW-1:0] mem_above [gblur_pkg::MAX_WIDTH];
    logic [PW-1:0] mem_two   [gblur_pkg::MAX_WIDTH];

    logic          s_accept;
    logic          cfg_wr;
    logic          a_move;
    logic          b_free;
    logic          emit;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [AW-1:0] x_eff;
    logic [HW-1:0] y_eff;
    logic          last_col;
    logic          last_row;
    logic          wrap_col;
    logic          wrap_row;
    logic [PW-1:0] above_col;
    logic [PW-1:0] two_col;
    logic [3:0]    new_pend;
    logic [3:0]    cur_oh;
    logic [3:0]    rest_pend;
    logic          sel_end;
    logic          sel_lrow;
    logic [PW-1:0] lpix [3];
    logic [PW-1:0] cpix [3];
    logic [PW-1:0] rpix [3];
    logic [PW-1:0] t_l, t_c, t_r, m_l, m_c, m_r;
    logic [PW-1:0] n_rgb;
    logic [gblur_pkg::COL_W-1:0] n_col;
    logic [gblur_pkg::ROW_W-1:0] n_row;

    // Effective frame size and the position of the incoming item.
    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (r_fw > WW'(gblur_pkg::MAX_WIDTH)) begin
            w_eff = WW'(gblur_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_fw;
        end
        h_eff    = (r_fh == '0) ? HW'(1) : r_fh;
        x_eff    = (WW'(r_col) >= w_eff) ? '0 : r_col;
        y_eff    = (r_row >= h_eff) ? '0 : r_row;
        last_col = (WW'(x_eff) == w_eff - WW'(1));
        last_row = (y_eff == h_eff - HW'(1));
        wrap_col = ((WW'(x_eff) + WW'(1)) >= w_eff);
        wrap_row = (((HW+1)'(y_eff) + (HW+1)'(1)) >= (HW+1)'(h_eff));
    end

    // Handshakes and stage movement.
    always_comb begin
        cfg_wr    = i_cfg_valid;
        cur_oh    = r_b_pend & (~r_b_pend + 4'd1);
        rest_pend = r_b_pend & ~cur_oh;
        emit      = (r_b_pend != '0) && (!r_o_vld || i_m_tready);
        b_free    = (r_b_pend == '0) || (emit && (rest_pend == '0));
        a_move    = r_a_vld && b_free;
        s_accept  = i_s_tvalid && o_s_tready;
    end

    assign o_s_tready  = !r_a_vld || a_move;
    assign o_cfg_ready = 1'b1;

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= gblur_pkg::FRAME_WIDTH_RST;
            r_fh  <= gblur_pkg::FRAME_HEIGHT_RST;
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == gblur_pkg::CFG_FRAME_WIDTH) begin
                r_fw  <= i_cfg_data[WW-1:0];
                r_col <= '0;
                r_row <= '0;
            end else if (i_cfg_index == gblur_pkg::CFG_FRAME_HEIGHT) begin
                r_fh  <= i_cfg_data[HW-1:0];
                r_col <= '0;
                r_row <= '0;
            end
        end else if (s_accept) begin
            if (wrap_col) begin
                r_col <= '0;
                r_row <= wrap_row ? '0 : y_eff + HW'(1);
            end else begin
                r_col <= x_eff + AW'(1);
                r_row <= y_eff;
            end
        end
    end

    // Forwarded column: a write of the item ahead lands on the edge of this read.
    assign above_col = r_a_fwd ? r_a_fa : r_a_above;
    assign two_col   = r_a_fwd ? r_a_ft : r_a_two;

    // Row stores: read at accept, written when the item enters the window.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_above <= mem_above[x_eff];
            r_a_two   <= mem_two[x_eff];
        end
        if (a_move) begin
            mem_above[r_a_x] <= r_a_pix;
            mem_two[r_a_x]   <= above_col;
        end
    end

    // Read stage payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_pix <= i_s_tdata[PW-1:0];
            r_a_x   <= x_eff;
            r_a_y   <= y_eff;
            r_a_lc  <= last_col;
            r_a_lr  <= last_row;
            r_a_fwd <= a_move && (r_a_x == x_eff);
            r_a_fa  <= r_a_pix;
            r_a_ft  <= above_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_accept) begin
            r_a_vld <= 1'b1;
        end else if (a_move) begin
            r_a_vld <= 1'b0;
        end
    end

    // Results owed by the item entering the window, in raster order.
    always_comb begin
        new_pend[0] = (r_a_y != '0) && (r_a_x != '0);
        new_pend[1] = (r_a_y != '0) && r_a_lc;
        new_pend[2] = r_a_lr && (r_a_x != '0);
        new_pend[3] = r_a_lr && r_a_lc;
    end

    // Window shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (a_move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[0][r] <= r_win[1][r];
                r_win[1][r] <= r_win[2][r];
            end
            r_win[2][0] <= two_col;
            r_win[2][1] <= above_col;
            r_win[2][2] <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_x <= r_a_x;
            r_b_y <= r_a_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_pend <= '0;
        end else if (a_move) begin
            r_b_pend <= new_pend;
        end else if (emit) begin
            r_b_pend <= rest_pend;
        end
    end

    // Neighborhood of the result being emitted, with borders replicated.
    always_comb begin
        sel_end  = cur_oh[1] || cur_oh[3];
        sel_lrow = cur_oh[2] || cur_oh[3];
        for (int r = 0; r < 3; r++) begin
            if (sel_end) begin
                lpix[r] = (r_b_x == '0) ? r_win[2][r] : r_win[1][r];
                cpix[r] = r_win[2][r];
            end else begin
                lpix[r] = (r_b_x == AW'(1)) ? r_win[1][r] : r_win[0][r];
                cpix[r] = r_win[1][r];
            end
            rpix[r] = r_win[2][r];
        end
        if (sel_lrow) begin
            t_l = (r_b_y == '0) ? lpix[2] : lpix[1];
            t_c = (r_b_y == '0) ? cpix[2] : cpix[1];
            t_r = (r_b_y == '0) ? rpix[2] : rpix[1];
            m_l = lpix[2];
            m_c = cpix[2];
            m_r = rpix[2];
        end else begin
            t_l = (r_b_y == HW'(1)) ? lpix[1] : lpix[0];
            t_c = (r_b_y == HW'(1)) ? cpix[1] : cpix[0];
            t_r = (r_b_y == HW'(1)) ? rpix[1] : rpix[0];
            m_l = lpix[1];
            m_c = cpix[1];
            m_r = rpix[1];
        end
        for (int ch = 0; ch < 3; ch++) begin
            n_rgb[ch*8 +: 8] = gblur_pkg::blur_chan(
                t_l[ch*8 +: 8], t_c[ch*8 +: 8], t_r[ch*8 +: 8],
                m_l[ch*8 +: 8], m_c[ch*8 +: 8], m_r[ch*8 +: 8],
                lpix[2][ch*8 +: 8], cpix[2][ch*8 +: 8], rpix[2][ch*8 +: 8]);
        end
        n_col = sel_end ? gblur_pkg::COL_W'(r_b_x)
                        : gblur_pkg::COL_W'(r_b_x - AW'(1));
        n_row = sel_lrow ? r_b_y : r_b_y - HW'(1);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_data <= {5'b0, n_row, n_col, n_rgb};
            r_o_last <= (rest_pend == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (emit) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

    // The window only advances once the previous item has no results left.
    `GBLUR_ASSERT_SAME(a_win_adv_clear, a_move, (r_b_pend == 4'd0) || (emit && $onehot(r_b_pend)))
    // Items of the first row that is not the last one owe no result.
    `GBLUR_ASSERT_NEXT(a_row0_silent, a_move && (r_a_y == '0) && !r_a_lr, r_b_pend == 4'd0)
    // The final result of an item is marked last on the output.
    `GBLUR_ASSERT_NEXT(a_last_marked, emit && $onehot(r_b_pend), o_m_tvalid && o_m_tlast)
    // A stalled input always means an item is held in the read stage.
    `GBLUR_ASSERT_SAME(a_stall_held, !o_s_tready, r_a_vld)

endmodule
